// ----- hw/rtl/memscan_pkg.sv -----
// Shared constants, codes and types for the memory word pattern scanner.
`timescale 1ns / 1ps

package memscan_pkg;

    localparam int WORD_BYTES        = 8;
    localparam int LANE_BYTES        = 4;
    localparam int DATA_BITS         = 64;
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int ADDRESS_BITS      = 48;
    localparam int HIT_FIFO_DEPTH    = 16;
    localparam int HIT_COUNT_W       = 20;
    localparam int MODE_W            = 2;
    localparam int LENGTH_W          = 5;
    localparam int CFG_INDEX_W       = 3;

    localparam logic [HIT_COUNT_W-1:0] HIT_LIMIT_RESET = HIT_COUNT_W'(200000);

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE    = 2'd0,
        MODE_POINTER = 2'd1,
        MODE_DWORD   = 2'd2
    } scan_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCAN_MODE     = 3'd0,
        REG_PATTERN_LOW   = 3'd1,
        REG_PATTERN_HIGH  = 3'd2,
        REG_PATTERN_LEN   = 3'd3,
        REG_RANGE_LOW     = 3'd4,
        REG_RANGE_HIGH    = 3'd5,
        REG_DWORD_VALUE   = 3'd6,
        REG_HIT_LIMIT     = 3'd7
    } cfg_index_t;

endpackage

// ----- hw/rtl/memscan_lane.sv -----
// One byte-pattern lane: checks whether the pattern ends at one byte position of the word.
`timescale 1ns / 1ps

module memscan_lane #(
    parameter int MAX_BYTES = memscan_pkg::MAX_PATTERN_BYTES
) (
    input  logic [MAX_BYTES-1:0][7:0]                               window,
    input  logic [MAX_BYTES-1:0][7:0]                               pattern,
    input  logic [$clog2(MAX_BYTES+1)-1:0]                          length,
    input  logic [$clog2(MAX_BYTES+memscan_pkg::WORD_BYTES+1)-1:0]  avail,
    output logic                                                    match
);

    localparam int LEN_W   = $clog2(MAX_BYTES + 1);
    localparam int AVAIL_W = $clog2(MAX_BYTES + memscan_pkg::WORD_BYTES + 1);

    logic [MAX_BYTES-1:0] byte_ok;

    // Byte k of the window lies k bytes before the end position.
    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            byte_ok[k] = (LEN_W'(k) >= length) || (window[k] == pattern[k]);
        end
        match = (length != '0) && (AVAIL_W'(length) <= avail) && (&byte_ok);
    end

endmodule

// ----- hw/rtl/memscan_merge.sv -----
// Hit queue and serializer: turns per-word hit masks into address-ordered hits with a limit.
`timescale 1ns / 1ps

module memscan_merge #(
    parameter int ADDRESS_BITS = memscan_pkg::ADDRESS_BITS,
    parameter int FIFO_DEPTH   = memscan_pkg::HIT_FIFO_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push_valid,
    output logic                                  push_ready,
    input  logic [memscan_pkg::WORD_BYTES-1:0]    push_mask,
    input  logic [ADDRESS_BITS-1:0]               push_base,
    input  logic [memscan_pkg::HIT_COUNT_W-1:0]   hit_limit,
    output logic                                  hit_valid,
    input  logic                                  hit_ready,
    output logic [ADDRESS_BITS-1:0]               hit_address,
    output logic                                  hit_last,
    output logic                                  hit_limit_reached
);

    localparam int WB     = memscan_pkg::WORD_BYTES;
    localparam int IDX_W  = $clog2(WB);
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int HC_W   = memscan_pkg::HIT_COUNT_W;

    logic [FIFO_DEPTH-1:0][WB-1:0]           mask_mem_reg;
    logic [FIFO_DEPTH-1:0][ADDRESS_BITS-1:0] base_mem_reg;
    logic [PTR_W-1:0]                        wr_ptr_reg;
    logic [PTR_W-1:0]                        rd_ptr_reg;
    logic [CNT_W-1:0]                        count_reg;
    logic [CNT_W-1:0]                        count_next;
    logic [WB-1:0]                           done_reg;
    logic [HC_W-1:0]                         hit_count_reg;
    logic                                    stopped_reg;
    logic                                    hit_valid_reg;
    logic [ADDRESS_BITS-1:0]                 hit_address_reg;
    logic                                    hit_last_reg;
    logic                                    hit_limit_reg;

    logic [WB-1:0]           head_mask;
    logic [ADDRESS_BITS-1:0] head_base;
    logic [WB-1:0]           remaining;
    logic [WB-1:0]           rest;
    logic [IDX_W-1:0]        bit_idx;
    logic                    found;
    logic                    is_last;
    logic [HC_W-1:0]         count_inc;
    logic                    at_limit;
    logic                    out_free;
    logic                    head_valid;
    logic                    push;
    logic                    pop;
    logic                    emit;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign push       = push_valid && push_ready;

    always_comb
    begin
        head_mask = mask_mem_reg[rd_ptr_reg];
        head_base = base_mem_reg[rd_ptr_reg];
        remaining = head_mask & ~done_reg;
        bit_idx   = '0;
        found     = 1'b0;
        for (int i = 0; i < WB; i++)
        begin
            if (remaining[i] && !found)
            begin
                bit_idx = IDX_W'(i);
                found   = 1'b1;
            end
        end
        rest       = remaining & ~(WB'(1) << bit_idx);
        is_last    = (rest == '0);
        count_inc  = hit_count_reg + HC_W'(1);
        at_limit   = (count_inc >= hit_limit);
        out_free   = !hit_valid_reg || hit_ready;
        head_valid = (count_reg != '0);
        emit       = head_valid && !stopped_reg && out_free;
        pop        = head_valid && (stopped_reg || (out_free && (is_last || at_limit)));
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mask_mem_reg[wr_ptr_reg] <= push_mask;
            base_mem_reg[wr_ptr_reg] <= push_base;
        end
        if (emit)
        begin
            hit_address_reg <= head_base + ADDRESS_BITS'(bit_idx);
            hit_last_reg    <= is_last || at_limit;
            hit_limit_reg   <= at_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            done_reg      <= '0;
            hit_count_reg <= '0;
            stopped_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
                done_reg   <= '0;
            end
            else if (emit)
            begin
                done_reg <= done_reg | (WB'(1) << bit_idx);
            end
            if (emit)
            begin
                hit_valid_reg <= 1'b1;
                hit_count_reg <= count_inc;
                if (at_limit)
                begin
                    stopped_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                hit_valid_reg <= 1'b0;
            end
        end
    end

    assign hit_valid         = hit_valid_reg;
    assign hit_address       = hit_address_reg;
    assign hit_last          = hit_last_reg;
    assign hit_limit_reached = hit_limit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("Hit queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (mask_mem_reg[rd_ptr_reg] != '0))
        else $error("Queued word carries no hits.");

    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid_reg && hit_limit_reg |-> hit_last_reg)
        else $error("Final hit before the limit is not marked last.");

    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && $past(stopped_reg) |-> !$rose(hit_valid_reg))
        else $error("Hit issued after the limit was reached.");

endmodule

// ----- hw/rtl/memory_word_pattern_scanner.sv -----
// Top level of the memory word pattern scanner: configuration, byte lanes and hit ordering.
//
//  Channel  | Direction | Handshake          | Contents
//  s_*      | in        | s_tvalid/s_tready  | memory word, address, region start
//  m_*      | out       | m_tvalid/m_tready  | hit address, last hit of word, limit
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// Each input word is scanned in the cycle it is accepted; one word per cycle is taken
// while the hit queue has room. Hits leave one per cycle while m_tready is high,
// from a 16-entry queue of words that hit; words without hits are not queued.
// s_tready drops only while the hit queue is full; a stalled m_tready fills the queue.
// Reset clears history fill, hit count and stop state; cfg_ready is always high.
`timescale 1ns / 1ps

module memory_word_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = memscan_pkg::MAX_PATTERN_BYTES,
    parameter int ADDRESS_BITS      = memscan_pkg::ADDRESS_BITS,
    parameter int HIT_FIFO_DEPTH    = memscan_pkg::HIT_FIFO_DEPTH
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // word_data, word_address
    input  logic [((memscan_pkg::DATA_BITS + ADDRESS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // region_start
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // hit_address
    output logic [((ADDRESS_BITS + 7) / 8) * 8 - 1:0]      m_tdata,
    output logic                                           m_tlast,
    // limit_reached
    output logic                                           m_tuser,
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready,
    input  logic [memscan_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [memscan_pkg::DATA_BITS-1:0]              cfg_data
);

    localparam int WB       = memscan_pkg::WORD_BYTES;
    localparam int LB       = memscan_pkg::LANE_BYTES;
    localparam int DW       = memscan_pkg::DATA_BITS;
    localparam int HB       = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int FILL_MAX = MAX_PATTERN_BYTES - 1;
    localparam int FILL_W   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int AVAIL_W  = $clog2(MAX_PATTERN_BYTES + WB + 1);
    localparam int LW       = memscan_pkg::LENGTH_W;
    localparam int HC_W     = memscan_pkg::HIT_COUNT_W;
    localparam int M_W      = ((ADDRESS_BITS + 7) / 8) * 8;

    logic [memscan_pkg::MODE_W-1:0] scan_mode_reg;
    logic [DW-1:0]                  pattern_low_reg;
    logic [DW-1:0]                  pattern_high_reg;
    logic [LW-1:0]                  pattern_length_reg;
    logic [DW-1:0]                  range_low_reg;
    logic [DW-1:0]                  range_high_reg;
    logic [31:0]                    dword_value_reg;
    logic [HC_W-1:0]                hit_limit_reg;

    logic [HB-1:0][7:0]             history_reg;
    logic [HB-1:0][7:0]             history_next;
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              fill_next;

    logic [DW-1:0]                  word_data;
    logic [ADDRESS_BITS-1:0]        word_address;
    logic                           accept;
    logic [FILL_W-1:0]              fill_eff;
    logic [AVAIL_W-1:0]             fill_sum;
    logic [HB+WB-1:0][7:0]          win;
    logic [15:0][7:0]               pattern_all;
    logic [MAX_PATTERN_BYTES-1:0][7:0] pattern_aligned;
    logic [LEN_W-1:0]               length_c;
    logic [LW-1:0]                  pattern_index;
    logic [WB-1:0]                  lane_match;
    logic [WB-1:0]                  hit_mask;
    logic [ADDRESS_BITS-1:0]        hit_base;
    logic                           push_ready;
    logic [ADDRESS_BITS-1:0]        hit_address;

    assign word_data    = s_tdata[DW-1:0];
    assign word_address = s_tdata[DW +: ADDRESS_BITS];
    assign accept       = s_tvalid && s_tready;
    assign s_tready     = push_ready;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg      <= memscan_pkg::MODE_BYTE;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            range_low_reg      <= '0;
            range_high_reg     <= '0;
            dword_value_reg    <= '0;
            hit_limit_reg      <= memscan_pkg::HIT_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (memscan_pkg::cfg_index_t'(cfg_index))
                memscan_pkg::REG_SCAN_MODE:    scan_mode_reg      <= cfg_data[memscan_pkg::MODE_W-1:0];
                memscan_pkg::REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                memscan_pkg::REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                memscan_pkg::REG_PATTERN_LEN:  pattern_length_reg <= cfg_data[LW-1:0];
                memscan_pkg::REG_RANGE_LOW:    range_low_reg      <= cfg_data;
                memscan_pkg::REG_RANGE_HIGH:   range_high_reg     <= cfg_data;
                memscan_pkg::REG_DWORD_VALUE:  dword_value_reg    <= cfg_data[31:0];
                memscan_pkg::REG_HIT_LIMIT:    hit_limit_reg      <= cfg_data[HC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The window holds the stored history bytes followed by the new word, oldest first.
    always_comb
    begin
        fill_eff = s_tuser ? '0 : fill_reg;
        for (int i = 0; i < HB; i++)
        begin
            win[i] = history_reg[i];
        end
        for (int j = 0; j < WB; j++)
        begin
            win[HB + j] = word_data[8*j +: 8];
        end
        for (int i = 0; i < HB; i++)
        begin
            history_next[i] = win[i + WB];
        end
        fill_sum  = AVAIL_W'(fill_eff) + AVAIL_W'(WB);
        fill_next = (fill_sum > AVAIL_W'(FILL_MAX)) ? FILL_W'(FILL_MAX) : FILL_W'(fill_sum);
    end

    // The pattern is reversed and aligned so that lane byte k compares with pattern byte len-1-k.
    always_comb
    begin
        pattern_all = {pattern_high_reg, pattern_low_reg};
        length_c = (pattern_length_reg > LW'(MAX_PATTERN_BYTES)) ?
                   LEN_W'(MAX_PATTERN_BYTES) : LEN_W'(pattern_length_reg);
        pattern_index = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            pattern_index      = LW'(length_c) - LW'(k) - LW'(1);
            pattern_aligned[k] = pattern_all[pattern_index[3:0]];
        end
    end

    for (genvar j = 0; j < WB; j++)
    begin : g_lane
        logic [MAX_PATTERN_BYTES-1:0][7:0] lane_window;
        logic [AVAIL_W-1:0]                lane_avail;

        for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
        begin : g_tap
            if (k <= HB + j)
            begin : g_in
                assign lane_window[k] = win[HB + j - k];
            end
            else
            begin : g_out
                assign lane_window[k] = 8'h00;
            end
        end

        assign lane_avail = AVAIL_W'(fill_eff) + AVAIL_W'(j + 1);

        memscan_lane #(
            .MAX_BYTES (MAX_PATTERN_BYTES)
        ) u_lane (
            .window  (lane_window),
            .pattern (pattern_aligned),
            .length  (length_c),
            .avail   (lane_avail),
            .match   (lane_match[j])
        );
    end

    // Hit j of a word lies at hit_base + j in every mode.
    always_comb
    begin
        hit_mask = '0;
        hit_base = word_address;
        case (memscan_pkg::scan_mode_t'(scan_mode_reg))
            memscan_pkg::MODE_BYTE:
            begin
                hit_mask = lane_match;
                hit_base = word_address - ADDRESS_BITS'(length_c) + ADDRESS_BITS'(1);
            end
            memscan_pkg::MODE_POINTER:
            begin
                hit_mask[0] = (word_data >= range_low_reg) && (word_data < range_high_reg);
            end
            memscan_pkg::MODE_DWORD:
            begin
                for (int j = 0; j < WB / LB; j++)
                begin
                    hit_mask[LB * j] = (word_data[32*j +: 32] == dword_value_reg);
                end
            end
            default:
            begin
                hit_mask = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            history_reg <= history_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    memscan_merge #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .FIFO_DEPTH   (HIT_FIFO_DEPTH)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .push_valid        (s_tvalid && (hit_mask != '0)),
        .push_ready        (push_ready),
        .push_mask         (hit_mask),
        .push_base         (hit_base),
        .hit_limit         (hit_limit_reg),
        .hit_valid         (m_tvalid),
        .hit_ready         (m_tready),
        .hit_address       (hit_address),
        .hit_last          (m_tlast),
        .hit_limit_reached (m_tuser)
    );

    assign m_tdata = M_W'(hit_address);

endmodule

// ----- bench/memscan_hit_checker.sv -----
// Checker for the memory word pattern scanner: predicts hits from accepted words and compares them.
`timescale 1ns / 1ps

module memscan_hit_checker (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    input  logic                                        s_tready,
    input  logic [((memscan_pkg::DATA_BITS + memscan_pkg::ADDRESS_BITS + 7) / 8) * 8 - 1:0]
                                                        s_tdata,
    input  logic                                        s_tuser,
    input  logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic [((memscan_pkg::ADDRESS_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                                        m_tlast,
    input  logic                                        m_tuser,
    input  logic                                        cfg_valid,
    input  logic                                        cfg_ready,
    input  logic [memscan_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [memscan_pkg::DATA_BITS-1:0]           cfg_data,
    output int                                          mismatch_count,
    output int                                          hits_waiting,
    output int                                          hits_checked,
    output logic [memscan_pkg::HIT_COUNT_W-1:0]         hit_total
);

    localparam int DATA_BITS         = memscan_pkg::DATA_BITS;
    localparam int ADDRESS_BITS      = memscan_pkg::ADDRESS_BITS;
    localparam int WORD_BYTES        = memscan_pkg::WORD_BYTES;
    localparam int LANE_BYTES        = memscan_pkg::LANE_BYTES;
    localparam int MAX_PATTERN_BYTES = memscan_pkg::MAX_PATTERN_BYTES;
    localparam int MODE_W            = memscan_pkg::MODE_W;
    localparam int LENGTH_W          = memscan_pkg::LENGTH_W;
    localparam int HIT_COUNT_W       = memscan_pkg::HIT_COUNT_W;
    localparam int HISTORY_BYTES     = MAX_PATTERN_BYTES - 1;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] address;
        logic                    last;
        logic                    limit;
    } scan_hit_t;

    scan_hit_t                      expected_hits[$];
    scan_hit_t                      want;
    logic [MODE_W-1:0]              mode;
    logic [8*MAX_PATTERN_BYTES-1:0] pattern;
    logic [LENGTH_W-1:0]            pattern_len;
    logic [DATA_BITS-1:0]           range_lo;
    logic [DATA_BITS-1:0]           range_hi;
    logic [31:0]                    dword_match;
    logic [HIT_COUNT_W-1:0]         hit_limit;
    logic [7:0]                     history[HISTORY_BYTES];
    int                             history_fill;
    logic                           stopped;

    task automatic predict_word_hits(input logic [DATA_BITS-1:0] data,
                                     input logic [ADDRESS_BITS-1:0] addr,
                                     input logic first);
        logic [7:0]              window[MAX_PATTERN_BYTES + WORD_BYTES];
        logic [ADDRESS_BITS-1:0] starts[$];
        scan_hit_t               burst[$];
        scan_hit_t               hit;
        int                      i;
        int                      j;
        int                      total;
        int                      len;
        int                      keep;
        int                      start;
        bit                      match;
        begin
            if (first)
                history_fill = 0;
            for (i = 0; i < history_fill; i++)
                window[i] = history[i];
            for (j = 0; j < WORD_BYTES; j++)
                window[history_fill + j] = data[8*j +: 8];
            total = history_fill + WORD_BYTES;

            case (mode)
                memscan_pkg::MODE_BYTE:
                begin
                    len = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                            : int'(pattern_len);
                    if (len > 0)
                    begin
                        for (j = 0; j < WORD_BYTES; j++)
                        begin
                            if (history_fill + j + 1 >= len)
                            begin
                                start = history_fill + j + 1 - len;
                                match = 1'b1;
                                for (i = 0; i < len; i++)
                                    if (window[start + i] != pattern[8*i +: 8])
                                        match = 1'b0;
                                if (match)
                                    starts.push_back(addr + ADDRESS_BITS'(j)
                                                     - ADDRESS_BITS'(len - 1));
                            end
                        end
                    end
                end
                memscan_pkg::MODE_POINTER:
                begin
                    if (data >= range_lo && data < range_hi)
                        starts.push_back(addr);
                end
                memscan_pkg::MODE_DWORD:
                begin
                    for (j = 0; j < WORD_BYTES / LANE_BYTES; j++)
                        if (data[32*j +: 32] == dword_match)
                            starts.push_back(addr + ADDRESS_BITS'(LANE_BYTES * j));
                end
                default:
                begin
                end
            endcase

            keep = (total < HISTORY_BYTES) ? total : HISTORY_BYTES;
            for (i = 0; i < keep; i++)
                history[i] = window[total - keep + i];
            history_fill = keep;

            for (i = 0; i < starts.size(); i++)
            begin
                if (!stopped)
                begin
                    hit_total = hit_total + 1'b1;
                    hit.address = starts[i];
                    hit.last = 1'b0;
                    hit.limit = 1'b0;
                    if (hit_total >= hit_limit)
                    begin
                        stopped = 1'b1;
                        hit.limit = 1'b1;
                    end
                    burst.push_back(hit);
                end
            end
            if (burst.size() > 0)
            begin
                hit = burst.pop_back();
                hit.last = 1'b1;
                burst.push_back(hit);
            end
            for (i = 0; i < burst.size(); i++)
                expected_hits.push_back(burst[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_hits.delete();
            mode = memscan_pkg::MODE_BYTE;
            pattern = '0;
            pattern_len = '0;
            range_lo = '0;
            range_hi = '0;
            dword_match = '0;
            hit_limit = memscan_pkg::HIT_LIMIT_RESET;
            foreach (history[k])
                history[k] = '0;
            history_fill = 0;
            stopped = 1'b0;
            hit_total = '0;
            mismatch_count = 0;
            hits_waiting = 0;
            hits_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("hit at address %h arrived with none expected", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    hits_checked++;
                    if (m_tdata !== want.address)
                    begin
                        $error("hit_address: expected %h, got %h", want.address, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_item: expected %b, got %b", want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.limit)
                    begin
                        $error("limit_reached: expected %b, got %b", want.limit, m_tuser);
                        mismatch_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    memscan_pkg::REG_SCAN_MODE:    mode = cfg_data[MODE_W-1:0];
                    memscan_pkg::REG_PATTERN_LOW:  pattern[63:0] = cfg_data;
                    memscan_pkg::REG_PATTERN_HIGH: pattern[127:64] = cfg_data;
                    memscan_pkg::REG_PATTERN_LEN:  pattern_len = cfg_data[LENGTH_W-1:0];
                    memscan_pkg::REG_RANGE_LOW:    range_lo = cfg_data;
                    memscan_pkg::REG_RANGE_HIGH:   range_hi = cfg_data;
                    memscan_pkg::REG_DWORD_VALUE:  dword_match = cfg_data[31:0];
                    memscan_pkg::REG_HIT_LIMIT:    hit_limit = cfg_data[HIT_COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (s_tvalid && s_tready)
                predict_word_hits(s_tdata[DATA_BITS-1:0],
                                  s_tdata[DATA_BITS +: ADDRESS_BITS], s_tuser);

            hits_waiting = expected_hits.size();
        end
    end

endmodule

// ----- bench/tb_memory_word_pattern_scanner.sv -----
// Testbench top for the memory word pattern scanner: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_memory_word_pattern_scanner;

    localparam int DATA_BITS         = memscan_pkg::DATA_BITS;
    localparam int ADDRESS_BITS      = memscan_pkg::ADDRESS_BITS;
    localparam int WORD_BYTES        = memscan_pkg::WORD_BYTES;
    localparam int LANE_BYTES        = memscan_pkg::LANE_BYTES;
    localparam int MAX_PATTERN_BYTES = memscan_pkg::MAX_PATTERN_BYTES;
    localparam int MODE_W            = memscan_pkg::MODE_W;
    localparam int LENGTH_W          = memscan_pkg::LENGTH_W;
    localparam int CFG_INDEX_W       = memscan_pkg::CFG_INDEX_W;
    localparam int HIT_COUNT_W       = memscan_pkg::HIT_COUNT_W;
    localparam int IN_BITS = ((DATA_BITS + ADDRESS_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int PRESSURE_WORDS = 24;
    localparam int DRAIN_LIMIT = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 14;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_BITS-1:0]     s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_BITS-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_BITS-1:0]   cfg_data = '0;

    int                     mismatch_count;
    int                     hits_waiting;
    int                     hits_checked;
    logic [HIT_COUNT_W-1:0] hit_total;

    int                     words_sent = 0;
    bit                     quiet = 1'b0;
    int                     holds_requested = 0;
    int                     holds_served = 0;
    int                     stall_left = 0;

    logic [8*MAX_PATTERN_BYTES-1:0] pattern_bits;
    logic [LENGTH_W-1:0]            pattern_len;
    int                             active_len;
    logic [7:0]                     alpha_a;
    logic [7:0]                     alpha_b;
    logic [7:0]                     byte_backlog[$];
    logic [DATA_BITS-1:0]           range_lo;
    logic [DATA_BITS-1:0]           range_hi;
    logic [31:0]                    dword_match;

    memory_word_pattern_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    memscan_hit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .hits_waiting   (hits_waiting),
        .hits_checked   (hits_checked),
        .hit_total      (hit_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (holds_requested != holds_served)
        begin
            holds_served <= holds_requested;
            stall_left <= LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic scan_memory_word(input logic [DATA_BITS-1:0] data,
                                    input logic [ADDRESS_BITS-1:0] addr,
                                    input logic first);
        int gap;
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= IN_BITS'({addr, data});
            s_tuser <= first;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            words_sent++;
        end
    endtask

    task automatic write_register(input memscan_pkg::cfg_index_t index,
                                  input logic [DATA_BITS-1:0] value);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= index;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic settle_block;
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (hits_waiting != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic choose_scan_setup(input logic [MODE_W-1:0] mode);
        int sel;
        int i;
        begin
            sel = $urandom_range(0, 19);
            write_register(memscan_pkg::REG_SCAN_MODE, DATA_BITS'(mode));
            case (mode)
                memscan_pkg::MODE_BYTE:
                begin
                    alpha_a = 8'($urandom);
                    alpha_b = 8'($urandom);
                    for (i = 0; i < MAX_PATTERN_BYTES; i++)
                        pattern_bits[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : ($urandom_range(0, 1) ? alpha_a : alpha_b);
                    if (sel == 0)
                        pattern_len = '0;
                    else if (sel == 1)
                        pattern_len = '1;
                    else if (sel < 5)
                        pattern_len = LENGTH_W'($urandom_range(9, MAX_PATTERN_BYTES));
                    else
                        pattern_len = LENGTH_W'($urandom_range(1, 8));
                    active_len = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                                  : int'(pattern_len);
                    byte_backlog.delete();
                    write_register(memscan_pkg::REG_PATTERN_LOW, pattern_bits[63:0]);
                    write_register(memscan_pkg::REG_PATTERN_HIGH, pattern_bits[127:64]);
                    write_register(memscan_pkg::REG_PATTERN_LEN, DATA_BITS'(pattern_len));
                end
                memscan_pkg::MODE_POINTER:
                begin
                    range_lo = {$urandom, $urandom};
                    if (sel < 3)
                        range_lo = DATA_BITS'($urandom_range(0, 255));
                    else if (sel < 6)
                        range_lo = ~DATA_BITS'($urandom_range(0, 4095));
                    range_hi = range_lo + DATA_BITS'($urandom_range(1, 4096));
                    if (sel == 19)
                        range_hi = range_lo - DATA_BITS'($urandom_range(0, 16));
                    write_register(memscan_pkg::REG_RANGE_LOW, range_lo);
                    write_register(memscan_pkg::REG_RANGE_HIGH, range_hi);
                end
                memscan_pkg::MODE_DWORD:
                begin
                    dword_match = (sel < 3) ? 32'($urandom_range(0, 3)) : $urandom;
                    write_register(memscan_pkg::REG_DWORD_VALUE, DATA_BITS'(dword_match));
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic next_word_data(input logic [MODE_W-1:0] mode,
                                  output logic [DATA_BITS-1:0] data);
        int i;
        int j;
        int pick;
        int count;
        begin
            data = {$urandom, $urandom};
            case (mode)
                memscan_pkg::MODE_BYTE:
                begin
                    for (j = 0; j < WORD_BYTES; j++)
                    begin
                        if (byte_backlog.size() == 0)
                        begin
                            pick = $urandom_range(0, 9);
                            if (pick < 4 && active_len > 0)
                                count = active_len;
                            else if (pick == 4 && active_len > 0)
                                count = $urandom_range(1, active_len);
                            else
                                count = 0;
                            for (i = 0; i < count; i++)
                                byte_backlog.push_back(pattern_bits[8*i +: 8]);
                            if (count == 0)
                                byte_backlog.push_back((pick == 5) ? 8'($urandom)
                                    : ($urandom_range(0, 1) ? alpha_a : alpha_b));
                        end
                        data[8*j +: 8] = byte_backlog.pop_front();
                    end
                end
                memscan_pkg::MODE_POINTER:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        data = range_lo + DATA_BITS'($urandom_range(0, 4095));
                    else if (pick == 4)
                        data = range_lo;
                    else if (pick == 5)
                        data = range_hi - 1'b1;
                    else if (pick == 6)
                        data = range_hi;
                end
                memscan_pkg::MODE_DWORD:
                begin
                    for (j = 0; j < WORD_BYTES / LANE_BYTES; j++)
                        if ($urandom_range(0, 4) < 2)
                            data[32*j +: 32] = dword_match;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    initial
    begin
        logic [DATA_BITS-1:0]    data;
        logic [ADDRESS_BITS-1:0] addr;
        logic                    first;
        logic [MODE_W-1:0]       mode;
        int                      phase;
        int                      n;
        int                      pick;
        int                      drain;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        scan_memory_word(64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b1);
        settle_block();
        write_register(memscan_pkg::REG_PATTERN_LOW, 64'h0000_0000_00CC_BBAA);
        write_register(memscan_pkg::REG_PATTERN_LEN, 64'd3);
        scan_memory_word(64'hBBAA_00CC_BBAA_1100, 48'h1000, 1'b1);
        scan_memory_word(64'h0000_0000_0000_00CC, 48'h1008, 1'b0);
        scan_memory_word(64'hBBAA_0000_0000_0000, 48'h2000, 1'b1);
        scan_memory_word(64'h0000_0000_0000_00CC, 48'h3000, 1'b1);
        scan_memory_word(64'hBBAA_0000_0000_0000, 48'hFFFF_FFFF_FFF8, 1'b1);
        scan_memory_word(64'h0000_0000_0000_00CC, 48'h0, 1'b0);
        scan_memory_word(64'h0000_0000_00CC_BBAA, 48'h5003, 1'b1);
        settle_block();
        write_register(memscan_pkg::REG_PATTERN_LOW, 64'h0706_0504_0302_0100);
        write_register(memscan_pkg::REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
        write_register(memscan_pkg::REG_PATTERN_LEN, 64'd31);
        scan_memory_word(64'h0706_0504_0302_0100, 48'h8000, 1'b1);
        scan_memory_word(64'h0F0E_0D0C_0B0A_0908, 48'h8008, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_PATTERN_LEN, 64'd16);
        scan_memory_word(64'h0302_0100_5555_5555, 48'h9000, 1'b1);
        scan_memory_word(64'h0B0A_0908_0706_0504, 48'h9008, 1'b0);
        scan_memory_word(64'h5555_5555_0F0E_0D0C, 48'h9010, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_SCAN_MODE, DATA_BITS'(memscan_pkg::MODE_POINTER));
        write_register(memscan_pkg::REG_RANGE_LOW, 64'h1000);
        write_register(memscan_pkg::REG_RANGE_HIGH, 64'h2000);
        scan_memory_word(64'h1000, 48'hA000, 1'b1);
        scan_memory_word(64'h1FFF, 48'hA008, 1'b0);
        scan_memory_word(64'h2000, 48'hA010, 1'b0);
        scan_memory_word(64'h0FFF, 48'hA018, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_RANGE_HIGH, 64'h1000);
        scan_memory_word(64'h1000, 48'hA020, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_RANGE_LOW, 64'h0);
        write_register(memscan_pkg::REG_RANGE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        scan_memory_word(64'h0, 48'hA028, 1'b0);
        scan_memory_word(64'hFFFF_FFFF_FFFF_FFFF, 48'hA030, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_SCAN_MODE, DATA_BITS'(memscan_pkg::MODE_DWORD));
        write_register(memscan_pkg::REG_DWORD_VALUE, 64'hDEAD_BEEF);
        scan_memory_word(64'hDEAD_BEEF_DEAD_BEEF, 48'hB000, 1'b1);
        scan_memory_word(64'hDEAD_BEEF_0000_0000, 48'hB008, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_DWORD_VALUE, 64'hFFFF_FFFF);
        scan_memory_word(64'hFFFF_FFFF_FFFF_FFFF, 48'hB010, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_SCAN_MODE, DATA_BITS'(MODE_UNUSED));
        scan_memory_word(64'hFFFF_FFFF_FFFF_FFFF, 48'hB018, 1'b0);
        settle_block();
        write_register(memscan_pkg::REG_HIT_LIMIT, DATA_BITS'({HIT_COUNT_W{1'b1}}));

        addr = 48'hB020;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_block();
            if (phase < 4)
                mode = MODE_W'(phase);
            else if ($urandom_range(0, 3) < 2)
                mode = memscan_pkg::MODE_BYTE;
            else
                mode = MODE_W'($urandom_range(1, 2));
            choose_scan_setup(mode);
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                first = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) == 0);
                if (first)
                begin
                    pick = $urandom_range(0, 9);
                    addr = ADDRESS_BITS'({$urandom, $urandom});
                    if (pick == 0)
                        addr = {ADDRESS_BITS{1'b1}}
                               - ADDRESS_BITS'(8 * $urandom_range(0, 3) + 7);
                    else if (pick > 1)
                        addr[2:0] = '0;
                    byte_backlog.delete();
                end
                else
                    addr = addr + ADDRESS_BITS'(WORD_BYTES);
                next_word_data(mode, data);
                scan_memory_word(data, addr, first);
            end
        end

        settle_block();
        quiet = 1'b1;
        write_register(memscan_pkg::REG_SCAN_MODE, DATA_BITS'(memscan_pkg::MODE_BYTE));
        write_register(memscan_pkg::REG_PATTERN_LOW, 64'hA5);
        write_register(memscan_pkg::REG_PATTERN_LEN, 64'd1);
        holds_requested++;
        for (n = 0; n < PRESSURE_WORDS; n++)
            scan_memory_word({8{8'hA5}}, ADDRESS_BITS'(48'h7000 + 8 * n), n == 0);

        settle_block();
        write_register(memscan_pkg::REG_HIT_LIMIT, DATA_BITS'(hit_total + 3'd3));
        for (n = 0; n < 6; n++)
            scan_memory_word({8{8'hA5}}, ADDRESS_BITS'(48'h7800 + 8 * n), n == 0);
        settle_block();
        write_register(memscan_pkg::REG_HIT_LIMIT, 64'd0);
        for (n = 0; n < 4; n++)
            scan_memory_word({8{8'hA5}}, ADDRESS_BITS'(48'h7900 + 8 * n), 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        drain = 0;
        while (hits_waiting != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (20) @(negedge clk);
        if (hits_waiting != 0)
            $error("%0d expected hits never arrived", hits_waiting);

        $display("Scanned %0d words in byte, pointer, dword and unused modes, with region breaks,",
                 words_sent);
        $display("address wrap, a long output stall and the hit limit stop; %0d hits compared.",
                 hits_checked);
        if (mismatch_count == 0 && hits_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
